### design/bsep_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the bilinear surface evaluator.
// Used by bsep_axis, bsep_coord and the top level; depends on nothing.
package bsep_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int COORD_BITS    = 32;
    localparam int PARAM_BITS    = 18;
    localparam int WRAP_BITS     = PARAM_BITS + 1;
    localparam int OUT_BITS      = 48;
    localparam int IDX_BITS      = 6;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 7;
    localparam int IN_DATA_BITS  = 2 * IDX_BITS + 3 * COORD_BITS + 2 * PARAM_BITS;
    localparam int OUT_DATA_BITS = 9 * OUT_BITS;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_EVAL = 1'b1
    } t_req;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_R_NODES    = 2'd0,
        CFG_S_NODES    = 2'd1,
        CFG_R_PERIODIC = 2'd2,
        CFG_S_PERIODIC = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_BITS-1:0] z;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
    } t_node;

endpackage

### design/bsep_axis.sv
`timescale 1ns / 1ps
// One parametric direction: periodic wrap, scaling by the cell count,
// cell selection with clamping and the two extrapolating weights. Uses bsep_pkg.
module bsep_axis #(
    parameter int DB = 6,
    parameter int WW = 28
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [bsep_pkg::PARAM_BITS-1:0] i_param,
    input  logic                                  i_periodic,
    input  logic [DB-1:0]                         i_d,
    output logic [DB-1:0]                         o_cell_next,
    output logic [DB-1:0]                         o_cell,
    output logic signed [WW-1:0]                  o_w0,
    output logic signed [WW-1:0]                  o_w1
);

    localparam int PB = bsep_pkg::WRAP_BITS;
    localparam int FB = bsep_pkg::FRAC_BITS;
    localparam int UW = PB + DB + 1;
    localparam logic signed [PB-1:0] ONE_P = PB'(2 ** FB);
    localparam logic signed [WW-1:0] ONE_W = WW'(2 ** FB);

    logic signed [PB-1:0] p_ext;
    logic signed [PB-1:0] p_wrap;
    logic signed [UW-1:0] n_u;
    logic signed [UW-1:0] r_u;
    logic signed [UW-1:0] fl;
    logic [DB-1:0]        dm1;
    logic [DB-1:0]        cell_idx;
    logic signed [WW-1:0] u_ext;
    logic signed [WW-1:0] cell_sh;
    logic signed [WW-1:0] a1;
    logic signed [WW-1:0] a0;
    logic [DB-1:0]        r_cell;
    logic signed [WW-1:0] r_w0;
    logic signed [WW-1:0] r_w1;

    assign p_ext = PB'(i_param);

    // A point exactly at 1.0 stays; points below 0 or strictly beyond 1.0 wrap.
    always_comb begin
        p_wrap = p_ext;
        if (i_periodic && p_ext < 0) begin
            p_wrap = p_ext + ONE_P;
        end else if (i_periodic && p_ext > ONE_P) begin
            p_wrap = p_ext - ONE_P;
        end
    end

    assign n_u = p_wrap * $signed({1'b0, i_d});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u <= n_u;
        end
    end

    // Arithmetic shift gives the floor for negative positions as well.
    assign fl  = r_u >>> FB;
    assign dm1 = i_d - DB'(1);

    always_comb begin
        if (fl < 0) begin
            cell_idx = '0;
        end else if (fl > $signed({{(UW-DB){1'b0}}, dm1})) begin
            cell_idx = dm1;
        end else begin
            cell_idx = fl[DB-1:0];
        end
    end

    assign u_ext   = WW'(r_u);
    assign cell_sh = WW'($signed({1'b0, cell_idx, {FB{1'b0}}}));
    assign a1      = u_ext - cell_sh;
    assign a0      = ONE_W - a1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= cell_idx;
            r_w0   <= a0;
            r_w1   <= a1;
        end
    end

    assign o_cell_next = cell_idx;
    assign o_cell      = r_cell;
    assign o_w0        = r_w0;
    assign o_w1        = r_w1;

endmodule

### design/bsep_coord.sv
`timescale 1ns / 1ps
// Position and both partials of one coordinate from the four corner nodes,
// five register stages with split wide products and saturation. Uses bsep_pkg.
module bsep_coord #(
    parameter int DB = 6,
    parameter int WW = 28
) (
    input  logic                                         i_clk,
    input  logic                                         i_en,
    input  logic [DB-1:0]                                i_d_r,
    input  logic [DB-1:0]                                i_d_s,
    input  logic signed [WW-1:0]                         i_a0,
    input  logic signed [WW-1:0]                         i_a1,
    input  logic signed [WW-1:0]                         i_b0,
    input  logic signed [WW-1:0]                         i_b1,
    input  logic                                         i_pr,
    input  logic                                         i_ps,
    input  logic [3:0][bsep_pkg::COORD_BITS-1:0]         i_bank,
    output logic [bsep_pkg::OUT_BITS-1:0]                o_pos,
    output logic [bsep_pkg::OUT_BITS-1:0]                o_ddr,
    output logic [bsep_pkg::OUT_BITS-1:0]                o_dds
);

    localparam int CW  = bsep_pkg::COORD_BITS;
    localparam int FB  = bsep_pkg::FRAC_BITS;
    localparam int OW  = bsep_pkg::OUT_BITS;
    localparam int MW  = WW + CW;
    localparam int EW  = MW + 1 - FB;
    localparam int DFW = CW + DB + 2;
    localparam int XW  = EW;
    localparam int LB  = XW / 2;
    localparam int HB  = XW - LB;
    localparam int PLW = WW + LB + 1;
    localparam int PHW = WW + HB;
    localparam int TW  = WW + XW + 2;
    localparam int VW  = TW - FB;

    logic signed [CW-1:0]  p00, p10, p01, p11;
    logic signed [CW:0]    df_r0, df_r1, df_s0, df_s1;
    logic signed [MW-1:0]  r_m00, r_m10, r_m01, r_m11;
    logic signed [DFW-1:0] r_dr0, r_dr1, r_ds0, r_ds1;
    logic signed [WW-1:0]  r3_a0, r3_a1, r3_b0, r3_b1;
    logic signed [MW:0]    sum0, sum1;
    logic signed [XW-1:0]  n_x [6];
    logic signed [WW-1:0]  n_w [6];
    logic signed [XW-1:0]  r_x [6];
    logic signed [WW-1:0]  r_w [6];
    logic signed [PLW-1:0] n_plo [6];
    logic signed [PHW-1:0] n_phi [6];
    logic signed [PLW-1:0] r_plo [6];
    logic signed [PHW-1:0] r_phi [6];
    logic signed [PLW:0]   n_ls [3];
    logic signed [PHW:0]   n_hs [3];
    logic signed [PLW:0]   r_ls [3];
    logic signed [PHW:0]   r_hs [3];
    logic signed [TW-1:0]  tot [3];
    logic [OW-1:0]         n_out [3];
    logic [OW-1:0]         r_out [3];

    function automatic logic [OW-1:0] sat_out(input logic [VW-1:0] v);
        logic all_ones;
        logic all_zeros;
        begin
            all_ones  = &v[VW-1:OW-1];
            all_zeros = ~|v[VW-1:OW-1];
            if (all_ones || all_zeros) begin
                sat_out = v[OW-1:0];
            end else if (v[VW-1]) begin
                sat_out = {1'b1, {(OW-1){1'b0}}};
            end else begin
                sat_out = {1'b0, {(OW-1){1'b1}}};
            end
        end
    endfunction

    // The corners sit in the bank chosen by the parity of their indices.
    assign p00 = $signed(i_bank[{i_pr, i_ps}]);
    assign p10 = $signed(i_bank[{~i_pr, i_ps}]);
    assign p01 = $signed(i_bank[{i_pr, ~i_ps}]);
    assign p11 = $signed(i_bank[{~i_pr, ~i_ps}]);

    assign df_r0 = (CW+1)'(p10) - (CW+1)'(p00);
    assign df_r1 = (CW+1)'(p11) - (CW+1)'(p01);
    assign df_s0 = (CW+1)'(p01) - (CW+1)'(p00);
    assign df_s1 = (CW+1)'(p11) - (CW+1)'(p10);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m00 <= i_a0 * p00;
            r_m10 <= i_a1 * p10;
            r_m01 <= i_a0 * p01;
            r_m11 <= i_a1 * p11;
            r_dr0 <= df_r0 * $signed({1'b0, i_d_r});
            r_dr1 <= df_r1 * $signed({1'b0, i_d_r});
            r_ds0 <= df_s0 * $signed({1'b0, i_d_s});
            r_ds1 <= df_s1 * $signed({1'b0, i_d_s});
            r3_a0 <= i_a0;
            r3_a1 <= i_a1;
            r3_b0 <= i_b0;
            r3_b1 <= i_b1;
        end
    end

    // Edge interpolation along r; the floor comes from dropping fraction bits.
    assign sum0 = (MW+1)'(r_m00) + (MW+1)'(r_m10);
    assign sum1 = (MW+1)'(r_m01) + (MW+1)'(r_m11);

    always_comb begin
        n_x[0] = $signed(sum0[MW:FB]);
        n_x[1] = $signed(sum1[MW:FB]);
        n_x[2] = XW'(r_dr0);
        n_x[3] = XW'(r_dr1);
        n_x[4] = XW'(r_ds0);
        n_x[5] = XW'(r_ds1);
        n_w[0] = r3_b0;
        n_w[1] = r3_b1;
        n_w[2] = r3_b0;
        n_w[3] = r3_b1;
        n_w[4] = r3_a0;
        n_w[5] = r3_a1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 6; k++) begin
                r_x[k] <= n_x[k];
                r_w[k] <= n_w[k];
            end
        end
    end

    // Each weight times wide operand is split into a low unsigned half and
    // a high signed half; the registered halves are summed in pairs, registered again and recombined.
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_plo[k] = r_w[k] * $signed({1'b0, r_x[k][LB-1:0]});
            n_phi[k] = r_w[k] * $signed(r_x[k][XW-1:LB]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 6; k++) begin
                r_plo[k] <= n_plo[k];
                r_phi[k] <= n_phi[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_ls[k] = (PLW+1)'(r_plo[2*k]) + (PLW+1)'(r_plo[2*k+1]);
            n_hs[k] = (PHW+1)'(r_phi[2*k]) + (PHW+1)'(r_phi[2*k+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_ls[k] <= n_ls[k];
                r_hs[k] <= n_hs[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            tot[k]   = (TW'(r_hs[k]) <<< LB) + TW'(r_ls[k]);
            n_out[k] = sat_out(tot[k][TW-1:FB]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_out[k] <= n_out[k];
            end
        end
    end

    assign o_pos = r_out[0];
    assign o_ddr = r_out[1];
    assign o_dds = r_out[2];

endmodule

### design/bilinear_surface_eval_with_partials.sv
`timescale 1ns / 1ps
// Bilinear surface evaluator with first partials: top level with the node store.
// Depends on bsep_pkg, bsep_axis and bsep_coord.

// The block takes one item per clock and returns one result for each evaluate;
// load items give no result. The rate is set by the node store, which is cut
// into four banks by the parity of the r and s indices so that the four corners
// of a cell are read together, one from each bank. The store is not cleared
// after reset; every node that an evaluate reaches must have been loaded first.
// When the result register is full and not taken, the whole pipeline holds and
// the input stops accepting.
module bilinear_surface_eval_with_partials #(
    parameter int MAX_R_NODES = 64,
    parameter int MAX_S_NODES = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // Load or evaluate items.
    input  logic                                       i_s_tvalid,
    output logic                                       o_s_tready,
    // From bit 0: node_r_index, node_s_index, node_x, node_y, node_z,
    // param_r, param_s.
    input  logic [bsep_pkg::IN_DATA_BITS-1:0]          i_s_tdata,
    // req_type.
    input  logic                                       i_s_tuser,
    // Results.
    output logic                                       o_m_tvalid,
    input  logic                                       i_m_tready,
    // From bit 0: pos_x, pos_y, pos_z, dx_dr, dy_dr, dz_dr, dx_ds, dy_ds, dz_ds.
    output logic [bsep_pkg::OUT_DATA_BITS-1:0]         o_m_tdata,
    // Register writes.
    input  logic                                       i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  logic [bsep_pkg::CFG_IDX_BITS-1:0]          i_cfg_index,
    input  logic [bsep_pkg::CFG_DATA_BITS-1:0]         i_cfg_data
);

    localparam int CW   = bsep_pkg::COORD_BITS;
    localparam int IB   = bsep_pkg::IDX_BITS;
    localparam int PW   = bsep_pkg::PARAM_BITS;
    localparam int OW   = bsep_pkg::OUT_BITS;
    localparam int DRB  = $clog2(MAX_R_NODES);
    localparam int DSB  = $clog2(MAX_S_NODES);
    localparam int DB   = (DRB > DSB) ? DRB : DSB;
    localparam int RHB  = (DRB > 1) ? DRB - 1 : 1;
    localparam int SHB  = (DSB > 1) ? DSB - 1 : 1;
    localparam int AW   = RHB + SHB;
    localparam int BANK_DEPTH = 2 ** AW;
    localparam int WW   = bsep_pkg::WRAP_BITS + DB + 3;
    localparam int NV   = 8;

    logic                             adv;
    logic [NV-1:0]                    r_vld;
    logic [NV-1:0]                    n_vld;

    logic [bsep_pkg::CFG_DATA_BITS-1:0] r_r_nodes;
    logic [bsep_pkg::CFG_DATA_BITS-1:0] r_s_nodes;
    logic                             r_r_periodic;
    logic                             r_s_periodic;
    logic [DB-1:0]                    d_r;
    logic [DB-1:0]                    d_s;

    bsep_pkg::t_req                   r0_type;
    logic [IB-1:0]                    r0_ri;
    logic [IB-1:0]                    r0_si;
    bsep_pkg::t_node                  r0_node;
    logic signed [PW-1:0]             r0_pr;
    logic signed [PW-1:0]             r0_ps;
    bsep_pkg::t_req                   r1_type;
    logic [IB-1:0]                    r1_ri;
    logic [IB-1:0]                    r1_si;
    bsep_pkg::t_node                  r1_node;

    logic                             wr_ok;
    logic [1:0]                       wbank;
    logic [RHB:0]                     rie;
    logic [SHB:0]                     sie;
    logic [AW-1:0]                    waddr;

    logic [DB-1:0]                    cell_rn, cell_sn, cell_r, cell_s;
    logic signed [WW-1:0]             a0, a1, b0, b1;
    logic [3:0][CW-1:0]               q_x, q_y, q_z;
    logic [OW-1:0]                    pos_x, pos_y, pos_z;
    logic [OW-1:0]                    dx_dr, dy_dr, dz_dr;
    logic [OW-1:0]                    dx_ds, dy_ds, dz_ds;

    assign adv         = ~r_vld[NV-1] | i_m_tready;
    assign o_s_tready  = adv;
    assign o_m_tvalid  = r_vld[NV-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_nodes    <= 7'd2;
            r_s_nodes    <= 7'd2;
            r_r_periodic <= 1'b0;
            r_s_periodic <= 1'b0;
        end else if (i_cfg_valid) begin
            case (bsep_pkg::t_cfg_idx'(i_cfg_index))
                bsep_pkg::CFG_R_NODES:    r_r_nodes    <= i_cfg_data;
                bsep_pkg::CFG_S_NODES:    r_s_nodes    <= i_cfg_data;
                bsep_pkg::CFG_R_PERIODIC: r_r_periodic <= i_cfg_data[0];
                bsep_pkg::CFG_S_PERIODIC: r_s_periodic <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Node counts out of range act as the nearest legal count.
    always_comb begin
        if (r_r_nodes < 7'd2) begin
            d_r = DB'(1);
        end else if (32'(r_r_nodes) > MAX_R_NODES) begin
            d_r = DB'(MAX_R_NODES - 1);
        end else begin
            d_r = DB'(r_r_nodes - 7'd1);
        end
        if (r_s_nodes < 7'd2) begin
            d_s = DB'(1);
        end else if (32'(r_s_nodes) > MAX_S_NODES) begin
            d_s = DB'(MAX_S_NODES - 1);
        end else begin
            d_s = DB'(r_s_nodes - 7'd1);
        end
    end

    // Load items leave the valid chain once their write is done.
    always_comb begin
        n_vld    = r_vld;
        n_vld[0] = i_s_tvalid;
        n_vld[1] = r_vld[0];
        n_vld[2] = r_vld[1] & (r1_type == bsep_pkg::REQ_EVAL);
        for (int k = 3; k < NV; k++) begin
            n_vld[k] = r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_type   <= bsep_pkg::t_req'(i_s_tuser);
            r0_ri     <= i_s_tdata[IB-1:0];
            r0_si     <= i_s_tdata[2*IB-1:IB];
            r0_node.x <= i_s_tdata[2*IB+CW-1:2*IB];
            r0_node.y <= i_s_tdata[2*IB+2*CW-1:2*IB+CW];
            r0_node.z <= i_s_tdata[2*IB+3*CW-1:2*IB+2*CW];
            r0_pr     <= $signed(i_s_tdata[2*IB+3*CW+PW-1:2*IB+3*CW]);
            r0_ps     <= $signed(i_s_tdata[2*IB+3*CW+2*PW-1:2*IB+3*CW+PW]);
            r1_type   <= r0_type;
            r1_ri     <= r0_ri;
            r1_si     <= r0_si;
            r1_node   <= r0_node;
        end
    end

    bsep_axis #(.DB(DB), .WW(WW)) u_axis_r (
        .i_clk       (i_clk),
        .i_en        (adv),
        .i_param     (r0_pr),
        .i_periodic  (r_r_periodic),
        .i_d         (d_r),
        .o_cell_next (cell_rn),
        .o_cell      (cell_r),
        .o_w0        (a0),
        .o_w1        (a1)
    );

    bsep_axis #(.DB(DB), .WW(WW)) u_axis_s (
        .i_clk       (i_clk),
        .i_en        (adv),
        .i_param     (r0_ps),
        .i_periodic  (r_s_periodic),
        .i_d         (d_s),
        .o_cell_next (cell_sn),
        .o_cell      (cell_s),
        .o_w0        (b0),
        .o_w1        (b1)
    );

    // Loads write at the same stage where evaluates read, so item order holds.
    assign wr_ok = r_vld[1] && (r1_type == bsep_pkg::REQ_LOAD) && adv
                   && (32'(r1_ri) < MAX_R_NODES) && (32'(r1_si) < MAX_S_NODES);
    assign wbank = {r1_ri[0], r1_si[0]};
    assign rie   = (RHB+1)'(r1_ri);
    assign sie   = (SHB+1)'(r1_si);
    assign waddr = {rie[RHB:1], sie[SHB:1]};

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic PR = 1'(b / 2);
        localparam logic PS = 1'(b % 2);

        logic [DB:0]           rrow;
        logic [DB:0]           srow;
        logic [AW-1:0]         raddr;
        bsep_pkg::t_node       mem [BANK_DEPTH];
        bsep_pkg::t_node       r_q;

        always_comb begin
            if (cell_rn[0] == PR) begin
                rrow = {1'b0, cell_rn};
            end else begin
                rrow = {1'b0, cell_rn} + (DB+1)'(1);
            end
            if (cell_sn[0] == PS) begin
                srow = {1'b0, cell_sn};
            end else begin
                srow = {1'b0, cell_sn} + (DB+1)'(1);
            end
        end

        assign raddr = {rrow[RHB:1], srow[SHB:1]};

        always_ff @(posedge i_clk) begin
            if (wr_ok && wbank == 2'(b)) begin
                mem[waddr] <= r1_node;
            end
            if (adv) begin
                r_q <= mem[raddr];
            end
        end

        assign q_x[b] = r_q.x;
        assign q_y[b] = r_q.y;
        assign q_z[b] = r_q.z;
    end

    bsep_coord #(.DB(DB), .WW(WW)) u_coord_x (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_d_r  (d_r),
        .i_d_s  (d_s),
        .i_a0   (a0),
        .i_a1   (a1),
        .i_b0   (b0),
        .i_b1   (b1),
        .i_pr   (cell_r[0]),
        .i_ps   (cell_s[0]),
        .i_bank (q_x),
        .o_pos  (pos_x),
        .o_ddr  (dx_dr),
        .o_dds  (dx_ds)
    );

    bsep_coord #(.DB(DB), .WW(WW)) u_coord_y (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_d_r  (d_r),
        .i_d_s  (d_s),
        .i_a0   (a0),
        .i_a1   (a1),
        .i_b0   (b0),
        .i_b1   (b1),
        .i_pr   (cell_r[0]),
        .i_ps   (cell_s[0]),
        .i_bank (q_y),
        .o_pos  (pos_y),
        .o_ddr  (dy_dr),
        .o_dds  (dy_ds)
    );

    bsep_coord #(.DB(DB), .WW(WW)) u_coord_z (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_d_r  (d_r),
        .i_d_s  (d_s),
        .i_a0   (a0),
        .i_a1   (a1),
        .i_b0   (b0),
        .i_b1   (b1),
        .i_pr   (cell_r[0]),
        .i_ps   (cell_s[0]),
        .i_bank (q_z),
        .o_pos  (pos_z),
        .o_ddr  (dz_dr),
        .o_dds  (dz_ds)
    );

    assign o_m_tdata = {dz_ds, dy_ds, dx_ds, dz_dr, dy_dr, dx_dr, pos_z, pos_y, pos_x};

`ifndef SYNTH
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("pipeline valid bits moved while the result was stalled");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] && (r1_type == bsep_pkg::REQ_LOAD) && adv |=> !r_vld[2])
        else $error("load item continued past the node store");

    a_cell_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] && (r1_type == bsep_pkg::REQ_EVAL) |-> (cell_rn < d_r) && (cell_sn < d_s))
        else $error("selected cell lies outside the grid");
`endif

endmodule
